[hdl/rsas_pkg.sv]
package rsas_pkg;

  localparam int POS_W   = 16;
  localparam int GAIN_W  = 26;
  localparam int SUM_W   = 48;
  localparam int ERR_W   = 48;
  localparam int R_W     = 58;
  localparam int CAND_W  = 50;
  localparam int E_W     = 60;
  localparam int CNT_W   = 16;
  localparam int Q_DEPTH = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [ERR_W-1:0] ERR_MAX = '1;
  // ceil(2^35 / 25): n * 65536 / 100 == (n * RECIP_25) >> 21 for 16 bit n
  localparam logic [30:0] RECIP_25 = 31'd1374389535;
  localparam int RECIP_SHIFT = 21;

  localparam logic ACT_REGISTER = 1'b0;
  localparam logic ACT_UPDATE   = 1'b1;

  typedef enum logic [1:0] {
    REG_ALPHA_GAIN     = 2'd0,
    REG_UPDATE_ENABLED = 2'd1,
    REG_C_MIN          = 2'd2,
    REG_C_STEP         = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic        action;
    logic [31:0] response_value;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  best_index;
    logic [31:0] best_value;
    logic        applied;
    logic        changed;
    logic [15:0] nodes_seen;
    logic [15:0] broadcasts_seen;
    logic [15:0] updates_seen;
  } out_word_t;

  // one classified element on its way from the front to the back
  typedef struct packed {
    logic              action;
    logic              applied;
    logic              last;
    logic              in_range;
    logic [POS_W-1:0]  pos;
    logic [31:0]       value;
    logic [GAIN_W-1:0] gain;
    logic [CNT_W-1:0]  nodes;
    logic [CNT_W-1:0]  updates;
  } elem_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

[hdl/rsas_ram.sv]
module rsas_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/rsas_fifo.sv]
module rsas_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  rsas_pkg::elem_t wdata,
  input  logic          rd,
  output rsas_pkg::elem_t rdata,
  output logic          full,
  output logic          empty
);
  import rsas_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  elem_t          slots [Q_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(Q_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd && !empty) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(wr && !full) - CW'(rd && !empty);
    end
  end

endmodule

[hdl/rsas_front.sv]
module rsas_front #(
  parameter int GRID_POINTS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  rsas_pkg::in_word_t     item,
  input  logic [23:0]            alpha_gain,
  input  logic                   update_enabled,
  input  rsas_pkg::back_status_t status,
  output logic                   q_wr,
  output rsas_pkg::elem_t        q_data,
  input  logic                   q_full
);
  import rsas_pkg::*;

  localparam int PW = $clog2(GRID_POINTS + 1);

  logic [PW-1:0]     position;
  logic [CNT_W-1:0]  node_count;
  logic [CNT_W-1:0]  update_count;
  logic              run_applied;
  logic              run_action;
  logic [GAIN_W-1:0] run_gain;

  logic              first;
  logic              in_range;
  logic [CNT_W-1:0]  node_count_next;
  logic [CNT_W-1:0]  update_count_next;
  logic              run_applied_next;
  logic              run_action_next;
  logic [GAIN_W-1:0] run_gain_next;
  logic [46:0]       dyn_prod;

  assign full = q_full || status.clearing;
  assign q_wr = push && !full;

  assign first    = (position == '0);
  assign in_range = (position < PW'(GRID_POINTS));

  always_comb begin
    node_count_next   = node_count;
    update_count_next = update_count;
    run_applied_next  = run_applied;
    run_action_next   = run_action;
    run_gain_next     = run_gain;
    if (first) begin
      run_action_next = item.action;
      if (item.action == ACT_REGISTER) begin
        node_count_next  = sat_inc(node_count);
        run_applied_next = 1'b1;
      end else begin
        update_count_next = sat_inc(update_count);
        run_applied_next  = update_enabled;
      end
    end
    // dynamic gain: nodes / 100 in q16
    dyn_prod = 47'(node_count_next) * 47'(RECIP_25);
    if (first) begin
      run_gain_next = (alpha_gain == '0) ? dyn_prod[RECIP_SHIFT +: GAIN_W]
                                         : GAIN_W'(alpha_gain);
    end
  end

  always_comb begin
    q_data.action   = run_action_next;
    q_data.applied  = run_applied_next;
    q_data.last     = item.last;
    q_data.in_range = in_range;
    q_data.pos      = POS_W'(position);
    q_data.value    = item.response_value;
    q_data.gain     = run_gain_next;
    q_data.nodes    = node_count_next;
    q_data.updates  = update_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      node_count   <= '0;
      update_count <= '0;
      run_applied  <= 1'b0;
      run_action   <= 1'b0;
      run_gain     <= '0;
    end else if (q_wr) begin
      node_count   <= node_count_next;
      update_count <= update_count_next;
      run_applied  <= run_applied_next;
      run_action   <= run_action_next;
      run_gain     <= run_gain_next;
      if (item.last) begin
        position <= '0;
      end else if (in_range) begin
        position <= position + 1'b1;
      end
    end
  end

endmodule

[hdl/rsas_back.sv]
module rsas_back #(
  parameter int GRID_POINTS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rsas_pkg::elem_t        q_data,
  input  logic                   q_empty,
  output logic                   q_rd,
  input  logic [31:0]            c_min,
  input  logic [30:0]            c_step,
  output rsas_pkg::back_status_t status,
  output logic                   empty,
  input  logic                   pop,
  output rsas_pkg::out_word_t    result
);
  import rsas_pkg::*;

  localparam int IDX_W     = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
  localparam int DIV_BITS  = 4;
  localparam int DIV_ITERS = SUM_W / DIV_BITS;
  localparam int DCW       = $clog2(DIV_ITERS);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_READ  = 10'b0000000100,
    S_ADD   = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_MULH  = 10'b0000100000,
    S_MULL  = 10'b0001000000,
    S_CAND  = 10'b0010000000,
    S_ERR   = 10'b0100000000,
    S_END   = 10'b1000000000
  } state_t;

  state_t state;
  elem_t  cur;

  logic [IDX_W-1:0]        clr_addr;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [SUM_W-1:0]        ram_wdata;
  logic [SUM_W-1:0]        ram_rdata;

  logic                    neg;
  logic [SUM_W-1:0]        dq;
  logic [CNT_W:0]          rem;
  logic [DCW-1:0]          div_cnt;
  logic [R_W-1:0]          racc;
  logic signed [CAND_W-1:0] cand;

  logic [ERR_W-1:0]        min_err;
  logic [POS_W-1:0]        min_idx;
  logic signed [CAND_W-1:0] min_cand;
  logic [31:0]             opt_val;
  logic [POS_W-1:0]        opt_idx;
  logic [CNT_W-1:0]        bcast;
  logic                    out_valid;

  logic signed [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0]        sum_sat;
  logic [SUM_W-1:0]        dq_next;
  logic [CNT_W:0]          rem_next;
  logic [CNT_W:0]          trial;
  logic [30:0]             mul_a;
  logic [23:0]             mul_b;
  logic [54:0]             prod;
  logic signed [E_W-1:0]   e_val;
  logic [E_W-1:0]          e_abs;
  logic [ERR_W-1:0]        err;
  logic [31:0]             v_sat;
  logic                    out_load;
  logic                    changed;

  rsas_ram #(.WIDTH(SUM_W), .DEPTH(GRID_POINTS)) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur.pos[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign status.clearing = (state == S_CLEAR);
  assign q_rd  = (state == S_IDLE) && !q_empty;
  assign empty = !out_valid;

  // saturating read-modify-write of the sum entry
  always_comb begin
    sum_wide = $signed({ram_rdata[SUM_W-1], ram_rdata})
             + $signed({{(SUM_W - 31){cur.value[31]}}, cur.value});
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur.pos[IDX_W-1:0];
    ram_wdata = sum_sat;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_ADD) begin
      ram_we = 1'b1;
    end
  end

  // restoring divide, DIV_BITS quotient bits per cycle
  always_comb begin
    dq_next  = dq;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial   = {rem_next[CNT_W-1:0], dq_next[SUM_W-1]};
      dq_next = {dq_next[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, cur.nodes}) begin
        trial      = trial - {1'b0, cur.nodes};
        dq_next[0] = 1'b1;
      end
      rem_next = trial;
    end
  end

  // one shared multiplier for both gain products and the candidate
  always_comb begin
    unique case (state)
      S_MULH: begin
        mul_a = 31'(cur.gain);
        mul_b = dq[SUM_W-1:24];
      end
      S_MULL: begin
        mul_a = 31'(cur.gain);
        mul_b = dq[23:0];
      end
      default: begin
        mul_a = c_step;
        mul_b = 24'(cur.pos);
      end
    endcase
    prod = 55'(mul_a) * 55'(mul_b);
  end

  always_comb begin
    e_val = (neg ? -$signed({2'b00, racc}) : $signed({2'b00, racc}))
          - E_W'(cand);
    e_abs = e_val[E_W-1] ? E_W'(-e_val) : E_W'(e_val);
    err   = (e_abs > E_W'(ERR_MAX)) ? ERR_MAX : e_abs[ERR_W-1:0];
  end

  always_comb begin
    if (min_cand > CAND_W'(signed'(32'sh7fffffff))) begin
      v_sat = 32'h7fffffff;
    end else if (min_cand < CAND_W'(signed'(32'sh80000000))) begin
      v_sat = 32'h80000000;
    end else begin
      v_sat = min_cand[31:0];
    end
    changed  = cur.applied && (cur.action == ACT_UPDATE) && (v_sat != opt_val);
    out_load = (state == S_END) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
    if (state == S_ADD) begin
      neg     <= sum_sat[SUM_W-1];
      dq      <= sum_sat[SUM_W-1] ? SUM_W'(0) - sum_sat : sum_sat;
      rem     <= '0;
      div_cnt <= '0;
      racc    <= '0;
    end
    if (state == S_DIV) begin
      dq      <= dq_next;
      rem     <= rem_next;
      div_cnt <= div_cnt + 1'b1;
    end
    if (state == S_MULH) begin
      racc <= {prod[R_W-9:0], 8'b0};
    end
    if (state == S_MULL) begin
      racc <= racc + R_W'(prod >> 16);
    end
    if (state == S_CAND) begin
      cand <= CAND_W'($signed(c_min)) + $signed({1'b0, prod[CAND_W-2:0]});
    end
    if (out_load) begin
      result.best_index      <= cur.applied ? min_idx[9:0] : opt_idx[9:0];
      result.best_value      <= cur.applied ? v_sat : opt_val;
      result.applied         <= cur.applied;
      result.changed         <= changed;
      result.nodes_seen      <= cur.nodes;
      result.broadcasts_seen <= changed ? sat_inc(bcast) : bcast;
      result.updates_seen    <= cur.updates;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      min_err   <= '0;
      min_idx   <= '0;
      min_cand  <= '0;
      opt_val   <= '0;
      opt_idx   <= '0;
      bcast     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(GRID_POINTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            if (q_data.in_range && q_data.applied) begin
              state <= S_READ;
            end else if (q_data.last) begin
              state <= S_END;
            end
          end
        end
        S_READ: state <= S_ADD;
        S_ADD:  state <= (cur.nodes == '0) ? S_CAND : S_DIV;
        S_DIV: begin
          if (div_cnt == DCW'(DIV_ITERS - 1)) begin
            state <= S_MULH;
          end
        end
        S_MULH: state <= S_MULL;
        S_MULL: state <= S_CAND;
        S_CAND: state <= S_ERR;
        S_ERR: begin
          if (cur.pos == '0 || err < min_err) begin
            min_err  <= err;
            min_idx  <= cur.pos;
            min_cand <= cand;
          end
          state <= cur.last ? S_END : S_IDLE;
        end
        S_END: begin
          if (out_load) begin
            if (cur.applied) begin
              opt_val <= v_sat;
              opt_idx <= min_idx;
            end
            if (changed) begin
              bcast <= sat_inc(bcast);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("reset did not start the clearing pass");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> state == S_DIV || state == S_MULH)
    else $error("divider left early");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_END && (!out_valid || pop)) |=> out_valid && state == S_IDLE)
    else $error("run end lost its result");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> state == S_IDLE && !status.clearing)
    else $error("element taken while busy");

endmodule

[hdl/response_sum_argmin_selector_core.sv]
// an applied element in range passes the back end through read, add, the 4-bit-per-cycle
//   divider, both gain products, candidate and error; with no node registered yet, the
//   divider and products are skipped; a new element is taken only in the idle state
// a run result is loaded into the output register once any previous result has been popped
// reset: synchronous active high; the sum memory is then cleared, one entry per cycle, over
//   all GRID_POINTS entries, with full held high; configuration writes are taken throughout
module response_sum_argmin_selector_core #(
  parameter int GRID_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rsas_pkg::in_word_t item,
  output logic               empty,
  input  logic               pop,
  output rsas_pkg::out_word_t result,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rsas_pkg::*;

  // configuration registers
  logic [23:0] alpha_gain;
  logic        update_enabled;
  logic [31:0] c_min;
  logic [30:0] c_step;

  // front to back queue
  elem_t        q_wdata;
  elem_t        q_rdata;
  logic         q_wr;
  logic         q_rd;
  logic         q_full;
  logic         q_empty;
  back_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain     <= '0;
      update_enabled <= 1'b1;
      c_min          <= '0;
      c_step         <= 31'd6554;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_ALPHA_GAIN:     alpha_gain     <= cfg_data[23:0];
        REG_UPDATE_ENABLED: update_enabled <= cfg_data[0];
        REG_C_MIN:          c_min          <= cfg_data;
        REG_C_STEP:         c_step         <= cfg_data[30:0];
        default:            ;
      endcase
    end
  end

  // front: run bookkeeping, node and update counts, gain of the run
  rsas_front #(.GRID_POINTS(GRID_POINTS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .item           (item),
    .alpha_gain     (alpha_gain),
    .update_enabled (update_enabled),
    .status         (status),
    .q_wr           (q_wr),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  // short queue so the front keeps taking words while the back grinds
  rsas_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: sum update, scaled error, running argmin, run result
  rsas_back #(.GRID_POINTS(GRID_POINTS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .c_min   (c_min),
    .c_step  (c_step),
    .status  (status),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

[test/response_sum_argmin_selector_core_tb.sv]
`timescale 1ns / 1ps

module response_sum_argmin_selector_core_tb;
  import rsas_pkg::*;

  localparam int GRID = 1024;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 60;
  localparam longint SUM_HI = 64'sd140737488355327;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam logic [63:0] ERR_HI = 64'd281474976710655;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_word_t item = '0;
  logic empty;
  logic pop = 1'b0;
  out_word_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [31:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  response_sum_argmin_selector_core #(.GRID_POINTS(GRID)) i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the configuration
  logic [23:0] gain_reg = 24'd0;
  logic update_en = 1'b1;
  longint cand_base = 0;
  logic [30:0] cand_step = 31'd6554;

  // predictor copy of the block state
  longint sums[GRID];
  logic [15:0] n_nodes = '0, n_updates = '0, n_bcasts = '0;
  longint opt_value = 0;
  int opt_index = 0;
  int grid_pos = 0;
  logic [63:0] min_err = '0;
  int min_index = 0;
  logic cur_action = 1'b0;
  logic cur_applied = 1'b0;
  logic [63:0] cur_gain = '0;

  out_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;

  // sender burst state, receiver stall state
  int burst_left = 0;
  bit no_idle = 1'b0;
  int hold_req = 0;
  int stall_mode = 0;

  function automatic logic [15:0] sat_up(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic longint cand_at(input int i);
    return cand_base + longint'(i) * longint'({1'b0, cand_step});
  endfunction

  // g * trunc(sum / nodes) >> 16, split so the product stays in 64 bits
  function automatic longint scaled(input longint s, input logic [63:0] g,
                                    input logic [15:0] nodes);
    logic [63:0] mag, q, r;
    if (nodes == 0) return 0;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    q = mag / nodes;
    r = ((g * (q >> 24)) << 8) + ((g * (q & 64'hFFFFFF)) >> 16);
    return (s < 0) ? -longint'(r) : longint'(r);
  endfunction

  // advance the predictor by one accepted word
  task automatic model_word(input in_word_t w);
    longint v, s, e, bv;
    logic [63:0] err;
    out_word_t o;
    logic chg;
    v = longint'($signed(w.response_value));
    chg = 1'b0;
    if (grid_pos == 0) begin
      cur_action = w.action;
      if (w.action == ACT_REGISTER) begin
        n_nodes = sat_up(n_nodes);
        cur_applied = 1'b1;
      end else begin
        n_updates = sat_up(n_updates);
        cur_applied = update_en;
      end
      if (gain_reg == 0) cur_gain = ({48'd0, n_nodes} << 16) / 100;
      else cur_gain = {40'd0, gain_reg};
    end
    if (grid_pos < GRID) begin
      if (cur_applied) begin
        s = sums[grid_pos] + v;
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        sums[grid_pos] = s;
        e = scaled(s, cur_gain, n_nodes) - cand_at(grid_pos);
        err = (e < 0) ? 64'(-e) : 64'(e);
        if (err > ERR_HI) err = ERR_HI;
        if (grid_pos == 0 || err < min_err) begin
          min_err = err;
          min_index = grid_pos;
        end
      end
      grid_pos++;
    end
    if (w.last) begin
      grid_pos = 0;
      if (cur_applied) begin
        bv = cand_at(min_index);
        if (bv > 64'sd2147483647) bv = 64'sd2147483647;
        if (bv < -64'sd2147483648) bv = -64'sd2147483648;
        // only an update run that moves the optimum is a broadcast
        if (cur_action == ACT_UPDATE && bv != opt_value) begin
          chg = 1'b1;
          n_bcasts = sat_up(n_bcasts);
        end
        opt_value = bv;
        opt_index = min_index;
      end
      o.best_index = opt_index[9:0];
      o.best_value = opt_value[31:0];
      o.applied = cur_applied;
      o.changed = chg;
      o.nodes_seen = n_nodes;
      o.broadcasts_seen = n_bcasts;
      o.updates_seen = n_updates;
      expected_words = {expected_words, o};
    end
  endtask

  // send one word; the sender idles between bursts unless no_idle is set
  task automatic send_word(input in_word_t w);
    if (!no_idle && burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full);
    model_word(w);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ALPHA_GAIN:     gain_reg = data[23:0];
      REG_UPDATE_ENABLED: update_en = data[0];
      REG_C_MIN:          cand_base = longint'($signed(data));
      REG_C_STEP:         cand_step = data[30:0];
    endcase
    @(posedge clk);
  endtask

  // drain every expected word, then let dropped or ignored elements retire
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
      3: return $urandom_range(0, 32'h3FFFFF) - 32'h1FFFFF;
      default: return $urandom;
    endcase
  endfunction

  // one run of n elements; mixed flips the action of later elements at random
  task automatic send_run(input logic act, input int n, input bit mixed);
    in_word_t w;
    for (int k = 0; k < n; k++) begin
      w.action = (mixed && k > 0) ? logic'($urandom_range(0, 1)) : act;
      w.response_value = pick_value();
      w.last = (k == n - 1);
      send_word(w);
    end
  endtask

  // an update arriving before any node exists sees a zero scaled term
  task automatic test_zero_nodes();
    send_run(ACT_UPDATE, 3, 1'b0);
    send_run(ACT_UPDATE, 1, 1'b0);
  endtask

  // register runs at the value extremes, then updates on top of them
  task automatic test_register_update();
    in_word_t w;
    w = '{action: ACT_REGISTER, response_value: 32'h7FFFFFFF, last: 1'b0};
    send_word(w);
    w.response_value = 32'h80000000;
    send_word(w);
    w.response_value = 32'h00000000;
    send_word(w);
    w.response_value = 32'hFFFFFFFF;
    w.last = 1'b1;
    send_word(w);
    send_run(ACT_REGISTER, 4, 1'b0);
    send_run(ACT_UPDATE, 4, 1'b0);
    send_run(ACT_UPDATE, 2, 1'b0);
  endtask

  // disabled updates only count
  task automatic test_disabled_update();
    wait_idle();
    cfg_write(REG_UPDATE_ENABLED, 32'd0);
    send_run(ACT_UPDATE, 3, 1'b0);
    send_run(ACT_REGISTER, 2, 1'b0);
    wait_idle();
    cfg_write(REG_UPDATE_ENABLED, 32'd1);
  endtask

  task automatic test_mixed_actions();
    send_run(ACT_REGISTER, 3, 1'b1);
    send_run(ACT_UPDATE, 3, 1'b1);
  endtask

  // a run longer than the grid; the tail is dropped
  task automatic test_long_run();
    no_idle = 1'b1;
    send_run(ACT_UPDATE, GRID + 6, 1'b0);
    no_idle = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    hold_req = 400;
    no_idle = 1'b1;
    for (int r = 0; r < 10; r++) send_run(logic'(r & 1), 2, 1'b0);
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      case (ph % 4)
        0: cfg_write(REG_ALPHA_GAIN, 32'd0);
        1: cfg_write(REG_ALPHA_GAIN, 32'h00FFFFFF);
        2: cfg_write(REG_ALPHA_GAIN, 32'd1);
        default: cfg_write(REG_ALPHA_GAIN, $urandom_range(0, 32'h00FFFFFF));
      endcase
      case (ph % 3)
        0: cfg_write(REG_C_MIN, 32'h80000000);
        1: cfg_write(REG_C_MIN, 32'h7FFFFFFF);
        default: cfg_write(REG_C_MIN, $urandom);
      endcase
      case (ph % 5)
        0: cfg_write(REG_C_STEP, 32'd1);
        1: cfg_write(REG_C_STEP, 32'h7FFFFFFF);
        2: cfg_write(REG_C_STEP, 32'd6554);
        default: cfg_write(REG_C_STEP, $urandom_range(1, 32'h7FFFFFFF));
      endcase
      cfg_write(REG_UPDATE_ENABLED, 32'($urandom_range(0, 3) != 0));
      // some phases run without sender gaps
      no_idle = (ph % 4 == 3);
      repeat (5) send_run(logic'($urandom_range(0, 1)), $urandom_range(1, 5),
                          ($urandom_range(0, 9) == 0));
    end
    no_idle = 1'b0;
  endtask

  // receiver: stall pattern redrawn at random from three modes, long hold-off on request
  always @(posedge clk) begin
    int hold_left;
    if (rst) begin
      pop <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (cycles % 256 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        case (stall_mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 1) == 1);
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // compare each popped word with the oldest prediction
  always @(posedge clk) begin
    out_word_t o;
    if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, result);
        errors++;
      end else begin
        o = expected_words.pop_front();
        check_field("best_index", 32'(o.best_index), 32'(result.best_index));
        check_field("best_value", o.best_value, result.best_value);
        check_field("applied", 32'(o.applied), 32'(result.applied));
        check_field("changed", 32'(o.changed), 32'(result.changed));
        check_field("nodes_seen", 32'(o.nodes_seen), 32'(result.nodes_seen));
        check_field("broadcasts_seen", 32'(o.broadcasts_seen),
                    32'(result.broadcasts_seen));
        check_field("updates_seen", 32'(o.updates_seen), 32'(result.updates_seen));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    foreach (sums[i]) sums[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_zero_nodes();
    test_register_update();
    test_disabled_update();
    test_mixed_actions();
    test_long_run();
    test_backpressure();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
